FILE: sv/tlik_pkg.sv
// ----------------------------------------------------------------------------
// tlik_pkg
// Shared widths, constants and helper functions for the two-link IK core.
// ----------------------------------------------------------------------------
package tlik_pkg;

    localparam int LEN_W      = 14;   // link length, unsigned Q2.12
    localparam int ANG_W      = 16;   // output angle, signed Q4.12
    localparam int DW         = 48;   // cordic vector datapath
    localparam int ZW         = 29;   // cordic angle accumulator, Q.24
    localparam int CORDIC_MAX = 24;
    localparam int NORM_BIT   = 40;   // normalized magnitude sits in [2^40, 2^41)
    localparam int ISQ_IN_W   = 32;
    localparam int ISQ_OUT_W  = 16;
    localparam int ISQ_REM_W  = 20;
    localparam int CFG_IDX_W  = 2;

    localparam logic [LEN_W-1:0] LEN_RESET = 14'd4096;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_UPPER = 2'd0;
    localparam t_cfg_idx CFG_LOWER = 2'd1;

    typedef logic signed [DW-1:0] t_vec;
    typedef logic signed [ZW-1:0] t_ang;

    localparam t_ang PI_Q24 = 29'sd52707179;

    // atan(2^-i) in Q.24
    function automatic t_ang atan_entry(input int unsigned i);
        t_ang v;
        unique case (i)
            0:  v = 29'sd13176795;
            1:  v = 29'sd7778716;
            2:  v = 29'sd4110060;
            3:  v = 29'sd2086331;
            4:  v = 29'sd1047214;
            5:  v = 29'sd524117;
            6:  v = 29'sd262123;
            7:  v = 29'sd131069;
            8:  v = 29'sd65536;
            9:  v = 29'sd32768;
            10: v = 29'sd16384;
            11: v = 29'sd8192;
            12: v = 29'sd4096;
            13: v = 29'sd2048;
            14: v = 29'sd1024;
            15: v = 29'sd512;
            16: v = 29'sd256;
            17: v = 29'sd128;
            18: v = 29'sd64;
            19: v = 29'sd32;
            20: v = 29'sd16;
            21: v = 29'sd8;
            22: v = 29'sd4;
            23: v = 29'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [5:0] msb_pos(input logic [DW-1:0] m);
        logic [5:0] p;
        p = '0;
        for (int k = 0; k < DW; k++) begin
            if (m[k]) p = 6'(k);
        end
        return p;
    endfunction

    // Q.24 to Q.12, halves away from zero
    function automatic logic [ANG_W-1:0] round_q12(input logic signed [ZW:0] z);
        logic [ZW:0] mg;
        logic [ZW:0] q;
        logic [ZW:0] t;
        mg = z[ZW] ? ((ZW+1)'(0) - z) : z;
        q  = (mg + (ZW+1)'(2048)) >> 12;
        t  = z[ZW] ? ((ZW+1)'(0) - q) : q;
        return t[ANG_W-1:0];
    endfunction

endpackage

FILE: sv/tlik_isqrt.sv
// ----------------------------------------------------------------------------
// tlik_isqrt
// Pipelined floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module tlik_isqrt import tlik_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [ISQ_IN_W-1:0]  i_v,
    output logic [ISQ_OUT_W-1:0] o_root
);

    logic [ISQ_IN_W-1:0]  r_v    [0:ISQ_OUT_W-2];
    logic [ISQ_REM_W-1:0] r_rem  [0:ISQ_OUT_W-1];
    logic [ISQ_OUT_W-1:0] r_root [0:ISQ_OUT_W-1];

    for (genvar j = 0; j < ISQ_OUT_W; j++) begin : g_step
        logic [ISQ_IN_W-1:0]  v_in;
        logic [ISQ_REM_W-1:0] rem_in;
        logic [ISQ_OUT_W-1:0] root_in;
        logic [ISQ_REM_W-1:0] rem_sh;
        logic [ISQ_REM_W-1:0] trial;

        if (j == 0) begin : g_first
            assign v_in    = i_v;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign v_in    = r_v[j-1];
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
        end

        assign rem_sh = {rem_in[ISQ_REM_W-3:0], v_in[ISQ_IN_W-1-2*j -: 2]};
        assign trial  = ISQ_REM_W'({root_in, 2'b01});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem_sh >= trial) begin
                    r_rem[j]  <= rem_sh - trial;
                    r_root[j] <= {root_in[ISQ_OUT_W-2:0], 1'b1};
                end else begin
                    r_rem[j]  <= rem_sh;
                    r_root[j] <= {root_in[ISQ_OUT_W-2:0], 1'b0};
                end
            end
        end

        if (j < ISQ_OUT_W-1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) r_v[j] <= v_in;
            end
        end
    end

    assign o_root = r_root[ISQ_OUT_W-1];

endmodule

FILE: sv/tlik_cordic.sv
// ----------------------------------------------------------------------------
// tlik_cordic
// Pipelined vectoring cordic giving atan2(y, x) in Q.24 radians.
// ----------------------------------------------------------------------------
module tlik_cordic import tlik_pkg::*; #(
    parameter int ITERS = 16
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_vec i_y,
    input  t_vec i_x,
    output t_ang o_z
);

    // quadrant fix
    t_vec r0_x, r0_y;
    t_ang r0_z;
    logic r0_zero;
    logic c0_neg;

    assign c0_neg = i_x[DW-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_zero <= (i_x == '0) && (i_y == '0);
            r0_x    <= c0_neg ? -i_x : i_x;
            r0_y    <= c0_neg ? -i_y : i_y;
            r0_z    <= c0_neg ? (i_y[DW-1] ? -PI_Q24 : PI_Q24) : '0;
        end
    end

    // magnitude
    t_vec r1_x, r1_y, r1_m;
    t_ang r1_z;
    logic r1_zero;
    t_vec c1_my;

    assign c1_my = r0_y[DW-1] ? -r0_y : r0_y;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_m    <= (r0_x > c1_my) ? r0_x : c1_my;
            r1_x    <= r0_x;
            r1_y    <= r0_y;
            r1_z    <= r0_z;
            r1_zero <= r0_zero;
        end
    end

    // shift amount from leading one
    t_vec       r2_x, r2_y;
    t_ang       r2_z;
    logic       r2_zero;
    logic       r2_left;
    logic [5:0] r2_sh;
    logic [5:0] c2_pos;

    assign c2_pos = msb_pos(r1_m);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_left <= c2_pos < 6'(NORM_BIT);
            r2_sh   <= (c2_pos < 6'(NORM_BIT)) ? (6'(NORM_BIT) - c2_pos)
                                                : (c2_pos - 6'(NORM_BIT));
            r2_x    <= r1_x;
            r2_y    <= r1_y;
            r2_z    <= r1_z;
            r2_zero <= r1_zero;
        end
    end

    // rotation stages, index 0 holds the normalized vector
    t_vec r_x [0:ITERS];
    t_vec r_y [0:ITERS];
    t_ang r_z [0:ITERS];
    logic r_zero [0:ITERS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= r2_left ? (r2_x <<< r2_sh) : (r2_x >>> r2_sh);
            r_y[0]    <= r2_left ? (r2_y <<< r2_sh) : (r2_y >>> r2_sh);
            r_z[0]    <= r2_z;
            r_zero[0] <= r2_zero;
        end
    end

    for (genvar i = 0; i < ITERS; i++) begin : g_iter
        localparam t_ang K_ATAN = atan_entry(i);
        t_vec dx, dy;
        logic pos;

        assign dx  = r_x[i] >>> i;
        assign dy  = r_y[i] >>> i;
        assign pos = !r_y[i][DW-1] && (r_y[i] != '0);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (pos) begin
                    r_x[i+1] <= r_x[i] + dy;
                    r_y[i+1] <= r_y[i] - dx;
                    r_z[i+1] <= r_z[i] + K_ATAN;
                end else begin
                    r_x[i+1] <= r_x[i] - dy;
                    r_y[i+1] <= r_y[i] + dx;
                    r_z[i+1] <= r_z[i] - K_ATAN;
                end
                r_zero[i+1] <= r_zero[i];
            end
        end
    end

    assign o_z = r_zero[ITERS] ? '0 : r_z[ITERS];

endmodule

FILE: sv/two_link_inverse_kinematics_core.sv
// ----------------------------------------------------------------------------
// two_link_inverse_kinematics_core
// Both elbow solutions of a planar two-link arm for one target point.
//
// Takes one point (x, y, signed Q4.12) per cycle and returns shoulder and
// elbow angles (Q4.12 radians) for the elbow-up and elbow-down solutions plus
// a reachable flag. Throughput is one item per clock unless i_stall holds a
// valid output. Data pass the 16-stage square root and four parallel cordic
// pipelines. Link lengths are written through the config port (index 0 upper,
// 1 lower); the user must write them only while the core is idle (unchecked).
// ----------------------------------------------------------------------------
module two_link_inverse_kinematics_core import tlik_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [ANG_W-1:0] i_target_x,
    input  logic signed [ANG_W-1:0] i_target_y,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [ANG_W-1:0] o_shoulder_up,
    output logic signed [ANG_W-1:0] o_elbow_up,
    output logic signed [ANG_W-1:0] o_shoulder_down,
    output logic signed [ANG_W-1:0] o_elbow_down,
    output logic                    o_reachable,
    input  logic                    i_cfg_we,
    input  t_cfg_idx                i_cfg_idx,
    input  logic [LEN_W-1:0]        i_cfg_data
);

    localparam int ITERS   = (CORDIC_STAGES < CORDIC_MAX) ? CORDIC_STAGES : CORDIC_MAX;
    localparam int LAT     = 28 + ITERS;
    localparam int XY_DLY  = 21;
    localparam int AB_DLY  = 4;
    localparam int RCH_DLY = LAT - 3;

    // config
    logic [LEN_W-1:0] r_l1, r_l2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1 <= LEN_RESET;
            r_l2 <= LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_UPPER: r_l1 <= i_cfg_data;
                CFG_LOWER: r_l2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipe advances unless the output is held
    logic             en;
    logic [LAT-1:0]   r_vld;

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // squares
    logic [LEN_W:0]             s;
    logic [LEN_W-1:0]           d;
    logic signed [2*ANG_W-1:0]  r_xx, r_yy;
    logic [2*LEN_W+1:0]         r_ss;
    logic [2*LEN_W-1:0]         r_dd;
    logic signed [ANG_W-1:0]    r_f1_x, r_f1_y;

    assign s = {1'b0, r_l1} + {1'b0, r_l2};
    assign d = (r_l1 >= r_l2) ? (r_l1 - r_l2) : (r_l2 - r_l1);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xx   <= i_target_x * i_target_x;
            r_yy   <= i_target_y * i_target_y;
            r_ss   <= s * s;
            r_dd   <= d * d;
            r_f1_x <= i_target_x;
            r_f1_y <= i_target_y;
        end
    end

    // radicands, clamped
    logic [ISQ_IN_W-1:0]     r2;
    logic signed [ISQ_IN_W:0] ra_s, rb_s;
    logic [ISQ_IN_W-1:0]     r_ra, r_rb;
    logic                    r_f2_reach;

    assign r2   = {1'b0, r_xx[2*ANG_W-2:0]} + {1'b0, r_yy[2*ANG_W-2:0]};
    assign ra_s = $signed({3'b0, r_ss}) - $signed({1'b0, r2});
    assign rb_s = $signed({1'b0, r2}) - $signed({5'b0, r_dd});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ra       <= ra_s[ISQ_IN_W] ? '0 : ra_s[ISQ_IN_W-1:0];
            r_rb       <= rb_s[ISQ_IN_W] ? '0 : rb_s[ISQ_IN_W-1:0];
            r_f2_reach <= !ra_s[ISQ_IN_W] && !rb_s[ISQ_IN_W];
        end
    end

    logic [ISQ_OUT_W-1:0] a, b;

    tlik_isqrt u_sqrt_a (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_v    (r_ra),
        .o_root (a)
    );

    tlik_isqrt u_sqrt_b (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_v    (r_rb),
        .o_root (b)
    );

    // sin/cos terms without the common (a^2+b^2) factor
    logic [2*ISQ_OUT_W-1:0]        r_ab, r_aa, r_bb, r_ab2;
    logic [2*ISQ_OUT_W:0]          r_sa;
    logic signed [2*ISQ_OUT_W:0]   r_da;
    logic [LEN_W+2*ISQ_OUT_W:0]    r_p1;
    logic signed [DW-1:0]          r_p2;
    logic [LEN_W+2*ISQ_OUT_W-1:0]  r_nm;
    t_vec                          r_den, r_num, r_nnum;
    t_vec                          num_n;

    assign num_n = $signed({1'b0, r_nm, 1'b0});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ab   <= a * b;
            r_aa   <= a * a;
            r_bb   <= b * b;
            r_sa   <= {1'b0, r_aa} + {1'b0, r_bb};
            r_da   <= $signed({1'b0, r_bb}) - $signed({1'b0, r_aa});
            r_ab2  <= r_ab;
            r_p1   <= r_l1 * r_sa;
            r_p2   <= $signed({1'b0, r_l2}) * r_da;
            r_nm   <= r_l2 * r_ab2;
            r_den  <= $signed({1'b0, r_p1}) + r_p2;
            r_num  <= num_n;
            r_nnum <= -num_n;
        end
    end

    // side delays to line up with the cordic inputs and the output stage
    logic signed [ANG_W-1:0] r_xd [0:XY_DLY-1];
    logic signed [ANG_W-1:0] r_yd [0:XY_DLY-1];
    logic [ISQ_OUT_W-1:0]    r_ad [0:AB_DLY-1];
    logic [ISQ_OUT_W-1:0]    r_bd [0:AB_DLY-1];
    logic [RCH_DLY-1:0]      r_rd;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xd[0] <= r_f1_x;
            r_yd[0] <= r_f1_y;
            for (int k = 1; k < XY_DLY; k++) begin
                r_xd[k] <= r_xd[k-1];
                r_yd[k] <= r_yd[k-1];
            end
            r_ad[0] <= a;
            r_bd[0] <= b;
            for (int k = 1; k < AB_DLY; k++) begin
                r_ad[k] <= r_ad[k-1];
                r_bd[k] <= r_bd[k-1];
            end
            r_rd <= {r_rd[RCH_DLY-2:0], r_f2_reach};
        end
    end

    t_ang z_half, z_q, z_up, z_dn;

    tlik_cordic #(.ITERS(ITERS)) u_cordic_half (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   ($signed(DW'(r_ad[AB_DLY-1]))),
        .i_x   ($signed(DW'(r_bd[AB_DLY-1]))),
        .o_z   (z_half)
    );

    tlik_cordic #(.ITERS(ITERS)) u_cordic_q (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   (DW'(r_yd[XY_DLY-1])),
        .i_x   (DW'(r_xd[XY_DLY-1])),
        .o_z   (z_q)
    );

    tlik_cordic #(.ITERS(ITERS)) u_cordic_up (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   (r_num),
        .i_x   (r_den),
        .o_z   (z_up)
    );

    tlik_cordic #(.ITERS(ITERS)) u_cordic_dn (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   (r_nnum),
        .i_x   (r_den),
        .o_z   (z_dn)
    );

    // angle sums, then rounding into the output register
    logic signed [ZW:0]      r_dh, r_su, r_sd;
    logic [ANG_W-1:0]        el;
    logic [ANG_W-1:0]        r_o_su, r_o_sd, r_o_eu, r_o_ed;
    logic                    r_o_rch;

    assign el = round_q12(r_dh);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dh    <= {z_half, 1'b0};
            r_su    <= {z_q[ZW-1], z_q} - {z_up[ZW-1], z_up};
            r_sd    <= {z_q[ZW-1], z_q} - {z_dn[ZW-1], z_dn};
            r_o_su  <= round_q12(r_su);
            r_o_sd  <= round_q12(r_sd);
            r_o_eu  <= el;
            r_o_ed  <= ANG_W'(0) - el;
            r_o_rch <= r_rd[RCH_DLY-1];
        end
    end

    assign o_shoulder_up   = r_o_su;
    assign o_shoulder_down = r_o_sd;
    assign o_elbow_up      = r_o_eu;
    assign o_elbow_down    = r_o_ed;
    assign o_reachable     = r_o_rch;

    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled while output register empty");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted item missing from pipe");

    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(r_vld))
        else $error("pipe moved while output held");

    a_elbow_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_elbow_down == ANG_W'(ANG_W'(0) - o_elbow_up)))
        else $error("elbow solutions not mirrored");

endmodule

FILE: tb/two_link_inverse_kinematics_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_link_inverse_kinematics_core_test
// Self-checking bench for the two-link IK core: directed corner points and
// random targets under several link-length settings, with random idling on
// both channels and a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module two_link_inverse_kinematics_core_test import tlik_pkg::*; ();

    localparam int STAGES  = 16;
    localparam int LATENCY = 28 + STAGES;
    localparam longint PI_24 = 52707179;

    typedef struct packed {
        logic signed [ANG_W-1:0] x;
        logic signed [ANG_W-1:0] y;
    } t_point;

    typedef struct packed {
        logic [ANG_W-1:0] sh_up;
        logic [ANG_W-1:0] el_up;
        logic [ANG_W-1:0] sh_dn;
        logic [ANG_W-1:0] el_dn;
        logic             reach;
    } t_joints;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic signed [ANG_W-1:0] i_target_x = '0;
    logic signed [ANG_W-1:0] i_target_y = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic signed [ANG_W-1:0] o_shoulder_up;
    logic signed [ANG_W-1:0] o_elbow_up;
    logic signed [ANG_W-1:0] o_shoulder_down;
    logic signed [ANG_W-1:0] o_elbow_down;
    logic                    o_reachable;
    logic                    i_cfg_we = 1'b0;
    t_cfg_idx                i_cfg_idx = CFG_UPPER;
    logic [LEN_W-1:0]        i_cfg_data = '0;

    two_link_inverse_kinematics_core #(.CORDIC_STAGES(STAGES)) dut (.*);

    always #2 i_clk = ~i_clk;

    t_point  pending_points[$];
    t_joints expected_joints[$];
    longint  upper_len = 4096;
    longint  lower_len = 4096;
    int      errors = 0;
    bit      quiet_mode = 1'b0;
    bit      in_taken = 1'b0;

    const longint atan_q24[24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2};

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint res, bit_v;
        res = 0;
        bit_v = 64'sd1 << 62;
        while (bit_v > v) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (v >= res + bit_v) begin
                v = v - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, m, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? PI_24 : -PI_24;
            x = -x;
            y = -y;
        end
        m = abs64(x) > abs64(y) ? abs64(x) : abs64(y);
        while (m < (64'sd1 << 40)) begin
            m = m * 2; x = x * 2; y = y * 2;
        end
        while (m >= (64'sd1 << 41)) begin
            m = m >>> 1; x = floor_shift(x, 1); y = floor_shift(y, 1);
        end
        for (int i = 0; i < STAGES && i < 24; i++) begin
            dx = floor_shift(x, i);
            dy = floor_shift(y, i);
            if (y > 0) begin
                x = x + dy; y = y - dx; z = z + atan_q24[i];
            end else begin
                x = x - dy; y = y + dx; z = z - atan_q24[i];
            end
        end
        return z;
    endfunction

    function automatic longint to_q12(longint z);
        longint m;
        m = (abs64(z) + 2048) >>> 12;
        return z < 0 ? -m : m;
    endfunction

    function automatic t_joints solve_arm(t_point p);
        t_joints j;
        longint x, y, r2, s, d, ra, rb, a, b, el, num, den, q;
        x = p.x;
        y = p.y;
        r2 = x * x + y * y;
        s = upper_len + lower_len;
        d = abs64(upper_len - lower_len);
        ra = s * s - r2;
        rb = r2 - d * d;
        j.reach = (ra >= 0 && rb >= 0);
        if (ra < 0) ra = 0;
        if (rb < 0) rb = 0;
        a = int_sqrt(ra);
        b = int_sqrt(rb);
        el = to_q12(2 * vector_angle(a, b));
        num = 2 * lower_len * a * b;
        den = upper_len * (a * a + b * b) + lower_len * (b * b - a * a);
        q = vector_angle(y, x);
        j.sh_up = 16'(to_q12(q - vector_angle(num, den)));
        j.sh_dn = 16'(to_q12(q - vector_angle(-num, den)));
        j.el_up = 16'(el);
        j.el_dn = 16'(-el);
        return j;
    endfunction

    function automatic void queue_point(t_point p);
        pending_points = {pending_points, p};
    endfunction

    // driver: one item per handshake, random gaps unless quiet
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || in_taken) begin
                if (pending_points.size() > 0 &&
                    (quiet_mode || $urandom_range(99) >= 22)) begin
                    t_point p;
                    p = pending_points.pop_front();
                    i_target_x <= p.x;
                    i_target_y <= p.y;
                    i_valid <= 1'b1;
                    expected_joints = {expected_joints, solve_arm(p)};
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= quiet_mode ? 1'b0 : ($urandom_range(99) < 22);
        end
    end

    always @(posedge i_clk) begin
        // input handshake as seen at this edge
        in_taken = i_rst_n && i_valid && !o_stall;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_joints.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                t_joints e;
                e = expected_joints.pop_front();
                if (o_shoulder_up !== e.sh_up) begin
                    $error("shoulder_up exp %0d got %0d", $signed(e.sh_up), o_shoulder_up);
                    errors++;
                end
                if (o_elbow_up !== e.el_up) begin
                    $error("elbow_up exp %0d got %0d", $signed(e.el_up), o_elbow_up);
                    errors++;
                end
                if (o_shoulder_down !== e.sh_dn) begin
                    $error("shoulder_down exp %0d got %0d", $signed(e.sh_dn),
                           o_shoulder_down);
                    errors++;
                end
                if (o_elbow_down !== e.el_dn) begin
                    $error("elbow_down exp %0d got %0d", $signed(e.el_dn), o_elbow_down);
                    errors++;
                end
                if (o_reachable !== e.reach) begin
                    $error("reachable exp %0d got %0d", e.reach, o_reachable);
                    errors++;
                end
            end
        end
    end

    task automatic drain();
        while (pending_points.size() > 0 || expected_joints.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic set_links(logic [LEN_W-1:0] l1, logic [LEN_W-1:0] l2);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= CFG_UPPER; i_cfg_data <= l1;
        @(negedge i_clk);
        i_cfg_idx <= CFG_LOWER; i_cfg_data <= l2;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        upper_len = l1;
        lower_len = l2;
    endtask

    function automatic t_point mk(int x, int y);
        t_point p;
        p.x = 16'(x);
        p.y = 16'(y);
        return p;
    endfunction

    // most targets fall within or just beyond the reach so both branches show up
    task automatic queue_random(int n);
        int rad, ang;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(3) == 0) begin
                queue_point(mk($urandom, $urandom));
            end else begin
                rad = $urandom_range(32'(upper_len + lower_len + 200));
                if (rad > 32767) rad = 32767;
                ang = $urandom_range(6283);
                queue_point(mk(int'(rad * $cos(ang / 1000.0)),
                               int'(rad * $sin(ang / 1000.0))));
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed: origin, axes, extremes, negative x on both sides of y
        queue_point(mk(0, 0));
        queue_point(mk(8192, 0));
        queue_point(mk(0, 8192));
        queue_point(mk(-8192, 0));
        queue_point(mk(-4096, -1));
        queue_point(mk(-4096, 1));
        queue_point(mk(0, -8192));
        queue_point(mk(32767, 32767));
        queue_point(mk(-32768, -32768));
        queue_point(mk(-32768, 32767));
        queue_point(mk(4096, 4096));
        queue_point(mk(1, 0));
        queue_point(mk(5793, 5793));
        drain();
        set_links(14'd16383, 14'd0);
        queue_point(mk(16383, 0));
        queue_point(mk(-16383, 0));
        queue_point(mk(0, 0));
        queue_random(60);
        drain();
        set_links(14'd0, 14'd0);
        queue_point(mk(0, 0));
        queue_random(20);
        drain();
        set_links(14'd16383, 14'd16383);
        queue_random(200);
        drain();
        set_links(14'd6000, 14'd2500);
        queue_random(250);
        // long stretch with no idling
        drain();
        quiet_mode = 1'b1;
        queue_random(150);
        drain();
        quiet_mode = 1'b0;
        set_links(14'd1234, 14'd9000);
        queue_random(200);
        drain();
        set_links(14'($urandom), 14'($urandom));
        queue_random(200);
        drain();
        if (errors == 0)
            $display("PASS two_link_inverse_kinematics_core");
        else
            $display("FAIL two_link_inverse_kinematics_core");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL two_link_inverse_kinematics_core");
        $finish;
    end
endmodule

FILE: sim.f
sv/tlik_pkg.sv
sv/tlik_isqrt.sv
sv/tlik_cordic.sv
sv/two_link_inverse_kinematics_core.sv
tb/two_link_inverse_kinematics_core_test.sv
